// ===== rtl/core/gam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph adjacency store package
// Shared sizes, command and status codes, and the row-unit operation type.
// ----------------------------------------------------------------------------
package gam_pkg;

  localparam int MaxVerts = 16;
  localparam int IdxW     = $clog2(MaxVerts);
  localparam int CntW     = $clog2(MaxVerts + 1);
  localparam int ValW     = 32;

  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [MaxVerts-1:0] row_t;
  typedef logic [ValW-1:0]     val_t;

  // Command codes carried on the input tuser.
  localparam logic [1:0] CMD_ADD_VERT = 2'd0;
  localparam logic [1:0] CMD_DEL_VERT = 2'd1;
  localparam logic [1:0] CMD_ADD_EDGE = 2'd2;
  localparam logic [1:0] CMD_REM_EDGE = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Row unit operations.
  localparam logic [2:0] ROP_NONE    = 3'd0;
  localparam logic [2:0] ROP_SQUEEZE = 3'd1;
  localparam logic [2:0] ROP_SET     = 3'd2;
  localparam logic [2:0] ROP_CLEAR   = 3'd3;
  localparam logic [2:0] ROP_ZERO    = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    idx_t       rd_addr;
    idx_t       wr_addr;
    idx_t       pos;
  } row_op_t;

endpackage

// ===== rtl/core/graph_adjacency_matrix_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Undirected graph adjacency matrix store
// Command sequencer with value search, row close-up and result register.
// ----------------------------------------------------------------------------
// Each command takes one input transfer and gives one status transfer. The
// sequencer works on one command at a time, so the input is ready only while
// it is idle. With N stored vertices, the value search reads the value memory
// one entry per cycle, and a delete then rewrites all N adjacency rows one per
// cycle through the shared row unit. A finished status waits in an output
// register, so the next command is accepted while it is still held; a status
// that finishes while the previous one is still held stalls the sequencer
// until that one is taken.
module graph_adjacency_matrix_table
  import gam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // vertex_a [31:0], vertex_b [63:32]
  input  logic [1:0]  s_axis_tuser,   // command [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // status [1:0], zero [7:2]
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD    = 3'd1;
  localparam logic [2:0] S_SRCH   = 3'd2;
  localparam logic [2:0] S_DEL    = 3'd3;
  localparam logic [2:0] S_EDGE_A = 3'd4;
  localparam logic [2:0] S_EDGE_B = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state;
  logic [1:0] cmd;
  val_t       va;
  val_t       vb;
  cnt_t       total;
  cnt_t       cnt;
  cnt_t       cnt_inc;
  logic       rd_valid;
  idx_t       rd_idx;
  logic       fa;
  logic       fb;
  idx_t       ia;
  idx_t       ib;
  idx_t       del_idx;
  logic       wp_en;
  idx_t       wp_addr;
  logic [1:0] fin_status;
  logic       out_valid;
  logic [1:0] out_status;

  logic       in_xfer;
  logic       out_free;
  logic       issue;
  logic       match_a;
  logic       match_b;
  logic       del_hit;
  logic       ram_wr_en;
  idx_t       ram_wr_addr;
  val_t       ram_wr_data;
  logic       ram_rd_en;
  idx_t       ram_rd_addr;
  val_t       ram_rd_data;
  row_op_t    row_op;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_status};

  assign cnt_inc = cnt + cnt_t'(1);
  assign issue   = (state == S_SRCH) && (cnt < total);
  assign match_a = rd_valid && (ram_rd_data == va);
  assign match_b = rd_valid && (ram_rd_data == vb);
  assign del_hit = (state == S_SRCH) && (cmd == CMD_DEL_VERT) && match_a;

  // Value memory port control: search and close-up reads, add and shift writes.
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = cnt[IdxW-1:0];
    if (issue) begin
      ram_rd_en = 1'b1;
    end else if ((state == S_DEL) && (cnt_inc < total)) begin
      ram_rd_en   = 1'b1;
      ram_rd_addr = cnt_inc[IdxW-1:0];
    end
    ram_wr_en   = 1'b0;
    ram_wr_addr = wp_addr;
    ram_wr_data = ram_rd_data;
    if (wp_en) begin
      ram_wr_en = 1'b1;
    end else if ((state == S_ADD) && (total < cnt_t'(MaxVerts))) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = total[IdxW-1:0];
      ram_wr_data = va;
    end
  end

  // Row unit control.
  always_comb begin
    row_op.op      = ROP_NONE;
    row_op.rd_addr = cnt[IdxW-1:0];
    row_op.wr_addr = cnt[IdxW-1:0];
    row_op.pos     = del_idx;
    unique case (state)
      S_ADD: begin
        row_op.wr_addr = total[IdxW-1:0];
        if (total < cnt_t'(MaxVerts)) begin
          row_op.op = ROP_ZERO;
        end
      end
      S_DEL: begin
        // Rows at or above the deleted index move down by one.
        if (cnt_inc == total) begin
          row_op.op = ROP_ZERO;
        end else begin
          row_op.op = ROP_SQUEEZE;
          if (cnt[IdxW-1:0] >= del_idx) begin
            row_op.rd_addr = cnt_inc[IdxW-1:0];
          end
        end
      end
      S_EDGE_A: begin
        row_op.op      = (cmd == CMD_ADD_EDGE) ? ROP_SET : ROP_CLEAR;
        row_op.rd_addr = ia;
        row_op.wr_addr = ia;
        row_op.pos     = ib;
      end
      S_EDGE_B: begin
        row_op.op      = (cmd == CMD_ADD_EDGE) ? ROP_SET : ROP_CLEAR;
        row_op.rd_addr = ib;
        row_op.wr_addr = ib;
        row_op.pos     = ia;
      end
      default: row_op.op = ROP_NONE;
    endcase
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      rd_valid  <= 1'b0;
      wp_en     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid  <= issue && !del_hit;
      // Shift the next value down one slot on the following cycle.
      wp_en     <= (state == S_DEL) && (cnt[IdxW-1:0] >= del_idx) && (cnt_inc < total);
      out_valid <= ((state == S_FIN) && out_free) || (out_valid && !m_axis_tready);
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= (s_axis_tuser == CMD_ADD_VERT) ? S_ADD : S_SRCH;
          end
        end
        S_ADD: begin
          if (total < cnt_t'(MaxVerts)) begin
            total      <= total + cnt_t'(1);
            fin_status <= ST_DONE;
          end else begin
            fin_status <= ST_FULL;
          end
          state <= S_FIN;
        end
        S_SRCH: begin
          if (cmd == CMD_DEL_VERT) begin
            if (match_a) begin
              del_idx <= rd_idx;
              state   <= S_DEL;
            end else if ((cnt == total) && !rd_valid) begin
              fin_status <= ST_NOT_FOUND;
              state      <= S_FIN;
            end
          end else if ((cnt == total) && !rd_valid) begin
            if (fa && fb) begin
              state <= S_EDGE_A;
            end else begin
              fin_status <= ST_NOT_FOUND;
              state      <= S_FIN;
            end
          end
        end
        S_DEL: begin
          if (cnt_inc == total) begin
            total      <= total - cnt_t'(1);
            fin_status <= ST_DONE;
            state      <= S_FIN;
          end
        end
        S_EDGE_A: begin
          state <= S_EDGE_B;
        end
        S_EDGE_B: begin
          fin_status <= ST_DONE;
          state      <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: command, search progress and result.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd <= s_axis_tuser;
      va  <= s_axis_tdata[31:0];
      vb  <= s_axis_tdata[63:32];
      fa  <= 1'b0;
      fb  <= 1'b0;
    end
    // A found delete restarts the count so the close-up pass covers every row.
    if (in_xfer || del_hit || (state == S_FIN)) begin
      cnt <= '0;
    end else if (issue || (state == S_DEL)) begin
      cnt <= cnt_inc;
    end
    if (issue) begin
      rd_idx <= cnt[IdxW-1:0];
    end
    // Edge endpoints keep the last matching entry.
    if ((state == S_SRCH) && match_a) begin
      fa <= 1'b1;
      ia <= rd_idx;
    end
    if ((state == S_SRCH) && match_b) begin
      fb <= 1'b1;
      ib <= rd_idx;
    end
    if (state == S_DEL) begin
      wp_addr <= cnt[IdxW-1:0];
    end
    if ((state == S_FIN) && out_free) begin
      out_status <= fin_status;
    end
  end

  gam_value_ram u_value_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  gam_adj_rows u_adj_rows (
    .clk    (clk),
    .rst    (rst),
    .row_op (row_op)
  );

endmodule

// ===== rtl/core/gam_value_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex value memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gam_value_ram
  import gam_pkg::*;
(
  input  logic clk,
  input  logic wr_en,
  input  idx_t wr_addr,
  input  val_t wr_data,
  input  logic rd_en,
  input  idx_t rd_addr,
  output val_t rd_data
);

  val_t mem [MaxVerts];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/gam_adj_rows.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjacency row file
// Holds the bit matrix and applies one row operation per cycle.
// ----------------------------------------------------------------------------
module gam_adj_rows
  import gam_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  row_op_t row_op
);

  row_t rows [MaxVerts];
  row_t src;
  row_t low_mask;
  row_t pos_bit;
  row_t result;
  logic wr_en;

  // Shared row unit: squeeze out a column, set or clear one bit, or zero.
  always_comb begin
    src      = rows[row_op.rd_addr];
    pos_bit  = row_t'(1) << row_op.pos;
    low_mask = pos_bit - row_t'(1);
    wr_en    = 1'b1;
    result   = src;
    unique case (row_op.op)
      ROP_SQUEEZE: result = (src & low_mask) | ((src >> 1) & ~low_mask);
      ROP_SET:     result = src | pos_bit;
      ROP_CLEAR:   result = src & ~pos_bit;
      ROP_ZERO:    result = '0;
      default:     wr_en  = 1'b0;
    endcase
  end

  // Row storage, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MaxVerts; r++) begin
        rows[r] <= '0;
      end
    end else if (wr_en) begin
      rows[row_op.wr_addr] <= result;
    end
  end

endmodule

// ===== tb/graph_adjacency_matrix_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph adjacency matrix store testbench
// Drives vertex and edge commands with random gaps and output stalls, keeps
// its own copy of the vertex list and edge matrix, and checks each status.
// ----------------------------------------------------------------------------
module graph_adjacency_matrix_table_tb
  import gam_pkg::*;
();

  localparam int CycleLimit = 400000;
  localparam int BurstLen   = 40;
  localparam int RandItems  = 750;
  localparam int PoolSize   = 12;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] va;
    logic [31:0] vb;
    bit          drain_first;
  } graph_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  graph_cmd_t  cmd_pending_q[$];
  logic [1:0]  status_expect_q[$];
  logic [31:0] value_pool[PoolSize];
  int          in_sent = 0;
  int          in_accepted = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          fail_count = 0;
  logic [31:0] cycle_count = '0;
  logic        calm;

  // Shadow copy of the vertex list and the symmetric edge matrix.
  logic [31:0] vert_val[MaxVerts];
  row_t        adj_row[MaxVerts] = '{default: '0};
  int          vert_count = 0;

  graph_adjacency_matrix_table dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // A quarter of the run has no idling on either side.
  assign calm = (cycle_count[9:8] == 2'b11);

  // Applies one command to the shadow graph and returns its status.
  function automatic logic [1:0] graph_apply(input logic [1:0] op, input logic [31:0] va,
                                             input logic [31:0] vb);
    int         i;
    int         del_idx;
    int         ia;
    int         ib;
    bit         fa;
    bit         fb;
    logic [1:0] st;
    st = ST_DONE;
    if (op == CMD_ADD_VERT) begin
      if (vert_count >= MaxVerts) begin
        st = ST_FULL;
      end else begin
        vert_val[vert_count] = va;
        adj_row[vert_count] = '0;
        for (i = 0; i < MaxVerts; i++) adj_row[i][vert_count] = 1'b0;
        vert_count++;
      end
    end else if (op == CMD_DEL_VERT) begin
      del_idx = -1;
      for (i = 0; i < vert_count; i++) begin
        if (del_idx < 0 && vert_val[i] == va) del_idx = i;
      end
      if (del_idx < 0) begin
        st = ST_NOT_FOUND;
      end else begin
        // Close up the list slot and the row, then drop the column bit.
        for (i = del_idx; i + 1 < vert_count; i++) begin
          vert_val[i] = vert_val[i + 1];
          adj_row[i] = adj_row[i + 1];
        end
        adj_row[vert_count - 1] = '0;
        vert_count--;
        for (i = 0; i < vert_count; i++) begin
          adj_row[i] = (adj_row[i] & ((row_t'(1) << del_idx) - row_t'(1)))
                     | ((adj_row[i] >> (del_idx + 1)) << del_idx);
        end
      end
    end else begin
      // Each endpoint resolves to its last matching entry.
      fa = 1'b0;
      fb = 1'b0;
      ia = 0;
      ib = 0;
      for (i = 0; i < vert_count; i++) begin
        if (vert_val[i] == va) begin
          ia = i;
          fa = 1'b1;
        end
        if (vert_val[i] == vb) begin
          ib = i;
          fb = 1'b1;
        end
      end
      if (!fa || !fb) begin
        st = ST_NOT_FOUND;
      end else if (op == CMD_ADD_EDGE) begin
        adj_row[ia][ib] = 1'b1;
        adj_row[ib][ia] = 1'b1;
      end else begin
        adj_row[ia][ib] = 1'b0;
        adj_row[ib][ia] = 1'b0;
      end
    end
    return st;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap(input logic quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Mostly values from the pool so that lookups hit, sometimes a fresh one.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, PoolSize - 1)];
    return $urandom;
  endfunction

  task automatic push_cmd(input logic [1:0] cmd, input logic [31:0] va, input logic [31:0] vb,
                          input bit drain_first);
    graph_cmd_t c;
    c.cmd = cmd;
    c.va = va;
    c.vb = vb;
    c.drain_first = drain_first;
    cmd_pending_q.insert(cmd_pending_q.size(), c);
  endtask

  task automatic report_mismatch(input string what, input logic [1:0] got,
                                 input logic [1:0] want);
    $display("%0t: %s: status got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Input driver: presents queued commands with random gaps between them.
  always @(negedge clk) begin
    graph_cmd_t c;
    logic       next_valid;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      // A presented command stays up until the monitor has seen its transfer.
      next_valid = (in_sent != in_accepted);
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_pending_q.size() != 0 &&
                     !(cmd_pending_q[0].drain_first && status_expect_q.size() != 0)) begin
          c = cmd_pending_q.pop_front();
          s_axis_tdata <= {c.vb, c.va};
          s_axis_tuser <= c.cmd;
          in_sent++;
          next_valid = 1'b1;
          gap_left = pick_gap(calm);
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Output ready with random stall runs.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b0);
    end
  end

  // Monitor: checks status transfers first, then predicts accepted commands.
  always @(posedge clk) begin
    logic [1:0] want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_expect_q.size() == 0) begin
          report_mismatch("unexpected status transfer", m_axis_tdata[1:0], 2'd0);
        end else begin
          want = status_expect_q.pop_front();
          if (m_axis_tdata[1:0] !== want) begin
            report_mismatch("status mismatch", m_axis_tdata[1:0], want);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        status_expect_q.insert(status_expect_q.size(),
                               graph_apply(s_axis_tuser, s_axis_tdata[31:0],
                                           s_axis_tdata[63:32]));
        in_accepted++;
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("graph_adjacency_matrix_table: mismatch");
      $finish;
    end
  end

  initial begin
    int i;
    int k;
    int mode;
    int r;
    int w_add;
    int w_del;
    int w_edge;
    logic [1:0] cmd;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (i = 4; i < PoolSize; i++) value_pool[i] = $urandom;

    // Directed part: empty store, extremes, duplicates, full store and the
    // special cases of edges and deletes.
    push_cmd(CMD_DEL_VERT, 32'h0000_0000, $urandom, 1'b0);
    push_cmd(CMD_ADD_EDGE, 32'h0000_0000, 32'h0000_0000, 1'b0);
    push_cmd(CMD_ADD_VERT, 32'h8000_0000, $urandom, 1'b0);
    push_cmd(CMD_ADD_VERT, 32'h7FFF_FFFF, $urandom, 1'b0);
    push_cmd(CMD_ADD_VERT, 32'h0000_0000, $urandom, 1'b0);
    push_cmd(CMD_ADD_VERT, 32'hFFFF_FFFF, $urandom, 1'b0);
    push_cmd(CMD_ADD_VERT, 32'h7FFF_FFFF, $urandom, 1'b0);
    for (i = 5; i < MaxVerts; i++) push_cmd(CMD_ADD_VERT, 32'h0000_1000 + i, $urandom, 1'b0);
    push_cmd(CMD_ADD_VERT, 32'h55AA_55AA, $urandom, 1'b0);
    push_cmd(CMD_ADD_EDGE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_cmd(CMD_ADD_EDGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_cmd(CMD_REM_EDGE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    push_cmd(CMD_ADD_EDGE, 32'h0000_0000, 32'h0BAD_F00D, 1'b0);
    push_cmd(CMD_DEL_VERT, 32'h7FFF_FFFF, $urandom, 1'b0);
    push_cmd(CMD_DEL_VERT, 32'h0BAD_F00D, $urandom, 1'b0);
    push_cmd(CMD_REM_EDGE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_cmd(CMD_DEL_VERT, 32'h8000_0000, $urandom, 1'b0);

    // Random part in bursts that favor growing, shrinking or mixed traffic,
    // so the store swings between empty and full with edges in between.
    for (k = 0; k < RandItems; k++) begin
      if (k % BurstLen == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: begin
          w_add = 55;
          w_del = 65;
          w_edge = 90;
        end
        1: begin
          w_add = 15;
          w_del = 60;
          w_edge = 85;
        end
        default: begin
          w_add = 30;
          w_del = 50;
          w_edge = 85;
        end
      endcase
      r = $urandom_range(0, 99);
      if (r < w_add) cmd = CMD_ADD_VERT;
      else if (r < w_del) cmd = CMD_DEL_VERT;
      else if (r < w_edge) cmd = CMD_ADD_EDGE;
      else cmd = CMD_REM_EDGE;
      if (cmd == CMD_ADD_VERT || cmd == CMD_DEL_VERT) begin
        push_cmd(cmd, pick_value(), $urandom, (k % 200) == 0);
      end else begin
        push_cmd(cmd, pick_value(), pick_value(), (k % 200) == 0);
      end
    end

    // Wait for reset release, the last command and its status.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (cmd_pending_q.size() != 0 || s_axis_tvalid || status_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("graph_adjacency_matrix_table: match");
    end else begin
      $display("graph_adjacency_matrix_table: mismatch");
    end
    $finish;
  end

endmodule
